// ===== rtl/tdct_pkg.sv =====
// tdct_pkg: shared types and codes for the triple down-counter timer
// beat structs for the item and result channels, op codes, register indexes
// no dependencies
package tdct_pkg;

    localparam int unsigned NUM_TIMERS = 3;
    localparam int unsigned HALF_W     = 17;
    localparam int unsigned COUNT_W    = 16;

    // op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_T1_LO = 3'd0;
    localparam logic [2:0] REG_T1_HI = 3'd1;
    localparam logic [2:0] REG_T2_LO = 3'd2;
    localparam logic [2:0] REG_T2_HI = 3'd3;
    localparam logic [2:0] REG_T3_LO = 3'd4;
    localparam logic [2:0] REG_T3_HI = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_index;
        logic [7:0] write_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [2:0] underflow_flags;
    } t_out_item;

endpackage

// ===== rtl/triple_down_counter_timer_unit.sv =====
// triple_down_counter_timer_unit: three 16-bit interval timers behind six byte registers
// counters, reload latch and run flags update in one pass; result held in an output register
// depends on tdct_pkg
//
// usage
//   item channel (i_in_valid / o_in_ready / i_in): one beat is a tick, a register
//   write or a register read. result channel (o_out_valid / i_out_ready / o_out):
//   exactly one beat per item, in item order.
//   a tick steps every running counter by one half step; a counter that reaches
//   zero raises its underflow flag in that tick's result. timer 1 then reloads
//   from its latch, timers 2 and 3 wrap on. a zero count or a zero latch gives
//   the full 65536-count period.
//   writes to timer 1 bytes load the reload latch and restart the count from it;
//   writes to timer 2/3 bytes replace one byte of the live count. a low-byte
//   write stops the timer, a high-byte write starts it. reads return a count
//   byte; unused indexes read 0 and ignore writes.
// throughput
//   one item per cycle while not stalled; each result appears in the next cycle.
//   all state updates sit between the item handshake and the output register.
// reset
//   synchronous, active low: counters, latch and run flags cleared, no result pending.
// stall
//   the output register holds its beat while i_out_ready is low; o_in_ready drops
//   only while a result waits and the receiver is not taking it.
module triple_down_counter_timer_unit
    import tdct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    // timer state
    logic [HALF_W-1:0]     r_half [NUM_TIMERS];
    logic [HALF_W-1:0]     n_half [NUM_TIMERS];
    logic [COUNT_W-1:0]    r_latch;
    logic [COUNT_W-1:0]    n_latch;
    logic [NUM_TIMERS-1:0] r_running;
    logic [NUM_TIMERS-1:0] n_running;

    // output register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic w_in_fire;

    // take a new item whenever the output slot is free or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // decode of the register index
    logic [1:0] w_sel;
    logic       w_high;
    logic       w_known;
    assign w_sel   = i_in.reg_index[2:1];
    assign w_high  = i_in.reg_index[0];
    assign w_known = (i_in.reg_index <= REG_T3_HI);

    always_comb begin
        logic [HALF_W-1:0] v_dec;
        logic [COUNT_W-1:0] v_latch;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            n_half[t] = r_half[t];
        end
        n_latch   = r_latch;
        n_running = r_running;
        n_out     = '0;
        v_dec     = '0;
        v_latch   = r_latch;

        case (i_in.op)
            OP_TICK: begin
                // each running timer steps one half count
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (r_running[t]) begin
                        v_dec = r_half[t] - HALF_W'(1);
                        if (v_dec == '0) begin
                            n_out.underflow_flags[t] = 1'b1;
                            // timer 1 reloads from its latch
                            if (t == 0) begin
                                v_dec = {r_latch, 1'b0};
                            end
                        end
                        n_half[t] = v_dec;
                    end
                end
            end
            OP_WRITE: begin
                if (w_known) begin
                    if (w_sel == 2'd0) begin
                        // timer 1: update latch and restart from it
                        if (w_high) begin
                            v_latch = {i_in.write_byte, r_latch[7:0]};
                        end else begin
                            v_latch = {r_latch[15:8], i_in.write_byte};
                        end
                        n_latch   = v_latch;
                        n_half[0] = {v_latch, 1'b0};
                    end else if (w_high) begin
                        // high count byte, half bit cleared
                        n_half[w_sel] = {i_in.write_byte, r_half[w_sel][8:1], 1'b0};
                    end else begin
                        // low count byte, half bit cleared
                        n_half[w_sel] = {r_half[w_sel][16:9], i_in.write_byte, 1'b0};
                    end
                    n_running[w_sel] = w_high;
                end
            end
            OP_READ: begin
                if (w_known) begin
                    if (w_high) begin
                        n_out.read_byte = r_half[w_sel][16:9];
                    end else begin
                        n_out.read_byte = r_half[w_sel][8:1];
                    end
                end
            end
            default: begin
                // unused op: no state change, zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_half[t] <= '0;
            end
            r_latch     <= '0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    r_half[t] <= n_half[t];
                end
                r_latch     <= n_latch;
                r_running   <= n_running;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with an accepted item
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // every accepted item yields a result beat next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> o_out_valid)
        else $error("no result beat after accepted item");

    // only ticks report underflow
    a_flags_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.op != OP_TICK) |=> o_out.underflow_flags == '0)
        else $error("underflow flags on a non-tick item");

    // only reads return a byte
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.op != OP_READ) |=> o_out.read_byte == '0)
        else $error("read byte on a non-read item");

    // a stopped timer 2 holds its count on a tick
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.op == OP_TICK && !r_running[1])
            |=> r_half[1] == $past(r_half[1]))
        else $error("stopped timer 2 changed on a tick");

    // timer 1 underflow reloads from the latch and flags
    a_t1_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.op == OP_TICK && r_running[0] && r_half[0] == 17'd1)
            |=> (r_half[0] == {r_latch, 1'b0}) && o_out.underflow_flags[0])
        else $error("timer 1 did not reload on underflow");
`endif

endmodule

// ===== tb/sv/triple_down_counter_timer_unit_tb.sv =====
// triple_down_counter_timer_unit_tb: self-checking bench for the triple interval timer
// drives tick, write and read beats, predicts every result beat and compares in order
// depends on tdct_pkg and triple_down_counter_timer_unit
module triple_down_counter_timer_unit_tb;
    import tdct_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int unsigned MAX_REPORTS     = 10;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    t_in_item  item_beat  = '0;
    logic      res_valid;
    logic      res_ready  = 1'b0;
    t_out_item res_beat;

    // idle odds in percent, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned items_sent     = 0;
    int unsigned mismatch_count = 0;

    // predicted timer state
    logic [16:0] half_cnt [NUM_TIMERS];
    logic [15:0] reload_lat;
    logic [2:0]  run_mask;

    t_out_item timer_results [$];

    triple_down_counter_timer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (item_valid),
        .o_in_ready  (item_ready),
        .i_in        (item_beat),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out       (res_beat)
    );

    always #5 clk = ~clk;

    function automatic t_in_item mk_item(input logic [1:0] op, input logic [2:0] idx,
                                         input logic [7:0] b);
        return '{op: op, reg_index: idx, write_byte: b};
    endfunction

    // advance the predicted timers by one beat and work out its result
    task automatic predict_timer_beat(input t_in_item it, output t_out_item res);
        logic [16:0] nxt;
        logic [1:0]  tmr;
        logic        hi;
        res = '0;
        tmr = it.reg_index[2:1];
        hi  = it.reg_index[0];
        case (it.op)
            OP_TICK: begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (run_mask[t]) begin
                        nxt = half_cnt[t] - 17'd1;
                        if (nxt == '0) begin
                            res.underflow_flags[t] = 1'b1;
                            // timer 1 reloads; a zero latch means the full period
                            if (t == 0) begin
                                nxt = {reload_lat, 1'b0};
                            end
                        end
                        half_cnt[t] = nxt;
                    end
                end
            end
            OP_WRITE: begin
                if (it.reg_index <= REG_T3_HI) begin
                    if (tmr == 2'd0) begin
                        if (hi) begin
                            reload_lat[15:8] = it.write_byte;
                        end else begin
                            reload_lat[7:0] = it.write_byte;
                        end
                        half_cnt[0] = {reload_lat, 1'b0};
                    end else if (hi) begin
                        half_cnt[tmr] = {it.write_byte, half_cnt[tmr][8:1], 1'b0};
                    end else begin
                        half_cnt[tmr] = {half_cnt[tmr][16:9], it.write_byte, 1'b0};
                    end
                    // low byte stops, high byte starts
                    run_mask[tmr] = hi;
                end
            end
            OP_READ: begin
                if (it.reg_index <= REG_T3_HI) begin
                    res.read_byte = hi ? half_cnt[tmr][16:9] : half_cnt[tmr][8:1];
                end
            end
            default: begin
            end
        endcase
    endtask

    // one beat on the item channel, with random idle cycles in front
    task automatic send_item(input t_in_item it);
        t_out_item res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_beat  <= it;
        do @(posedge clk); while (!item_ready);
        predict_timer_beat(it, res);
        timer_results.push_back(res);
        items_sent++;
    endtask

    // ticks carry random don't-care fields
    task automatic send_ticks(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_item(mk_item(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255))));
        end
    endtask

    // hold the sender until every predicted beat has come back
    task automatic wait_results_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (timer_results.size() != 0) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch on %s at %0t: expected %h got %h", what, $time, want_v, got_v);
        end
    endtask

    // receiver side: random stalls, applied at the falling edge
    always @(negedge clk) begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && res_valid && res_ready) begin
            if (timer_results.size() == 0) begin
                flag_mismatch("beat with nothing expected", 8'h00, res_beat.read_byte);
            end else begin
                want = timer_results.pop_front();
                if (res_beat.read_byte !== want.read_byte) begin
                    flag_mismatch("read_byte", want.read_byte, res_beat.read_byte);
                end
                if (res_beat.underflow_flags !== want.underflow_flags) begin
                    flag_mismatch("underflow_flags", 8'(want.underflow_flags),
                                  8'(res_beat.underflow_flags));
                end
            end
        end
    end

    task automatic test_reset_state();
        send_item(mk_item(OP_READ, REG_T1_LO, 8'h00));
        send_item(mk_item(OP_READ, REG_T2_HI, 8'hff));
        send_item(mk_item(OP_READ, REG_T3_HI, 8'h00));
        send_item(mk_item(OP_READ, REG_SPARE_B, 8'hff));
    endtask

    // byte lanes at their extremes, unused indexes and the unused op
    task automatic test_register_access();
        send_item(mk_item(OP_WRITE, REG_T2_LO, 8'hff));
        send_item(mk_item(OP_WRITE, REG_T2_HI, 8'hff));
        send_item(mk_item(OP_READ, REG_T2_LO, 8'h00));
        send_item(mk_item(OP_READ, REG_T2_HI, 8'h00));
        send_item(mk_item(OP_WRITE, REG_SPARE_A, 8'hff));
        send_item(mk_item(OP_READ, REG_SPARE_A, 8'h00));
        send_item(mk_item(OP_NONE, REG_SPARE_B, 8'hff));
        send_item(mk_item(OP_WRITE, REG_T2_LO, 8'h00));
    endtask

    // timer 1 reload on underflow, timer 3 wrapping past zero
    task automatic test_underflow();
        send_item(mk_item(OP_WRITE, REG_T1_LO, 8'h01));
        send_item(mk_item(OP_WRITE, REG_T1_HI, 8'h00));
        send_item(mk_item(OP_WRITE, REG_T3_LO, 8'h01));
        send_item(mk_item(OP_WRITE, REG_T3_HI, 8'h00));
        send_ticks(3);
        send_item(mk_item(OP_READ, REG_T3_HI, 8'h00));
        send_item(mk_item(OP_READ, REG_T1_LO, 8'h00));
    endtask

    // zero start and zero latch wrap to the top of the full 65536-count period
    task automatic test_full_period();
        send_item(mk_item(OP_WRITE, REG_T1_LO, 8'h00));
        send_item(mk_item(OP_WRITE, REG_T1_HI, 8'h00));
        send_item(mk_item(OP_WRITE, REG_T2_LO, 8'h00));
        send_item(mk_item(OP_WRITE, REG_T2_HI, 8'h00));
        send_item(mk_item(OP_WRITE, REG_T3_LO, 8'h00));
        send_ticks(3);
        send_item(mk_item(OP_READ, REG_T1_HI, 8'h00));
        send_item(mk_item(OP_READ, REG_T1_LO, 8'h00));
        send_item(mk_item(OP_READ, REG_T2_HI, 8'h00));
        send_item(mk_item(OP_READ, REG_T2_LO, 8'h00));
        send_item(mk_item(OP_READ, REG_T3_LO, 8'h00));
    endtask

    // mostly program-then-tick sequences with small counts so underflows are common
    task automatic test_random_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        logic [1:0]  tmr;
        logic [7:0]  lo_b;
        logic [7:0]  hi_b;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                tmr  = 2'($urandom_range(2));
                lo_b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(12));
                hi_b = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00;
                if ($urandom_range(9) != 0) begin
                    send_item(mk_item(OP_WRITE, {tmr, 1'b0}, lo_b));
                end
                if ($urandom_range(6) != 0) begin
                    send_item(mk_item(OP_WRITE, {tmr, 1'b1}, hi_b));
                end
            end else if (pick < 72) begin
                send_ticks(($urandom_range(15) == 0) ? $urandom_range(40, 300)
                                                      : $urandom_range(1, 12));
            end else if (pick < 90) begin
                send_item(mk_item(OP_READ, 3'($urandom_range(7)), 8'($urandom_range(255))));
            end else begin
                send_item(mk_item(2'($urandom_range(3)), 3'($urandom_range(7)),
                                  8'($urandom_range(255))));
            end
        end
    endtask

    initial begin
        half_cnt   = '{default: '0};
        reload_lat = '0;
        run_mask   = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls often
        send_idle_pct = 17;
        recv_idle_pct = 68;
        test_reset_state();
        test_register_access();
        test_underflow();
        test_random_traffic(560);
        wait_results_drained();

        // the other way round
        send_idle_pct = 68;
        recv_idle_pct = 17;
        test_random_traffic(560);
        wait_results_drained();

        // back to back in both directions
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(560);
        test_full_period();

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && timer_results.size() == 0) begin
            $display("triple_down_counter_timer_unit_tb: PASS");
        end else begin
            $display("triple_down_counter_timer_unit_tb: FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("triple_down_counter_timer_unit_tb: FAIL");
        $finish;
    end

endmodule
